[src/cpualu_pkg.sv]
// Shared types and constants for the CPU ALU with flag register.
package cpualu_pkg;

  // Operation codes; codes above FN_ADDSP are reserved
  typedef enum logic [5:0] {
    FN_ADD   = 6'd0,
    FN_ADC   = 6'd1,
    FN_SUB   = 6'd2,
    FN_SBC   = 6'd3,
    FN_AND   = 6'd4,
    FN_XOR   = 6'd5,
    FN_OR    = 6'd6,
    FN_CP    = 6'd7,
    FN_INC   = 6'd8,
    FN_DEC   = 6'd9,
    FN_RLCA  = 6'd10,
    FN_RLA   = 6'd11,
    FN_RRCA  = 6'd12,
    FN_RRA   = 6'd13,
    FN_RLC   = 6'd14,
    FN_RL    = 6'd15,
    FN_RRC   = 6'd16,
    FN_RR    = 6'd17,
    FN_SLA   = 6'd18,
    FN_SRA   = 6'd19,
    FN_SRL   = 6'd20,
    FN_SWAP  = 6'd21,
    FN_BIT   = 6'd22,
    FN_RES   = 6'd23,
    FN_SET   = 6'd24,
    FN_DAA   = 6'd25,
    FN_CPL   = 6'd26,
    FN_SCF   = 6'd27,
    FN_CCF   = 6'd28,
    FN_ADD16 = 6'd29,
    FN_ADDSP = 6'd30
  } func_t;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  typedef struct packed {
    logic [15:0] value;
    logic        writes;
    flags_t      flags;
  } alu_res_t;

  // Decimal adjust constants
  localparam logic [7:0] DAA_LIMIT = 8'h99;
  localparam logic [7:0] DAA_HI    = 8'h60;
  localparam logic [7:0] DAA_LO    = 8'h06;
  localparam logic [3:0] NIB_LIMIT = 4'h9;

endpackage

[src/cpualu_core.sv]
// Combinational ALU datapath: value, write enable and new flags for one word.
module cpualu_core (
  input  logic [5:0]          func,
  input  logic [15:0]         operand_a,
  input  logic [15:0]         operand_b,
  input  logic [2:0]          bit_index,
  input  cpualu_pkg::flags_t  flags_in,
  output cpualu_pkg::alu_res_t res
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic        cin;
  logic        cuse;
  logic [8:0]  sum9;
  logic [4:0]  hsum5;
  logic [8:0]  dif9;
  logic [4:0]  hdif5;
  logic [7:0]  rot_v;
  logic [7:0]  rot_r;
  logic        rot_c;
  logic [7:0]  daa_v;
  logic        daa_c;
  logic [16:0] add16;
  logic [12:0] h16;
  logic [15:0] sp_ext;
  logic [4:0]  sp_h;
  logic [8:0]  sp_c;
  logic [7:0]  r8;

  assign a     = operand_a[7:0];
  assign b     = operand_b[7:0];
  assign cin   = flags_in.c;
  // carry-in only for the with-carry forms
  assign cuse  = ((func == cpualu_pkg::FN_ADC) || (func == cpualu_pkg::FN_SBC)) ? cin : 1'b0;

  assign sum9  = {1'b0, a} + {1'b0, b} + {8'd0, cuse};
  assign hsum5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cuse};
  assign dif9  = {1'b0, a} - {1'b0, b} - {8'd0, cuse};
  assign hdif5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cuse};

  assign add16  = {1'b0, operand_a} + {1'b0, operand_b};
  assign h16    = {1'b0, operand_a[11:0]} + {1'b0, operand_b[11:0]};
  assign sp_ext = {{8{b[7]}}, b};
  assign sp_h   = {1'b0, operand_a[3:0]} + {1'b0, b[3:0]};
  assign sp_c   = {1'b0, operand_a[7:0]} + {1'b0, b};

  // rotates: accumulator forms read A, prefixed forms read B
  always_comb begin
    rot_v = (func <= cpualu_pkg::FN_RRA) ? a : b;
    rot_r = '0;
    rot_c = 1'b0;
    case (func)
      cpualu_pkg::FN_RLCA, cpualu_pkg::FN_RLC: begin
        rot_c = rot_v[7];
        rot_r = {rot_v[6:0], rot_v[7]};
      end
      cpualu_pkg::FN_RLA, cpualu_pkg::FN_RL: begin
        rot_c = rot_v[7];
        rot_r = {rot_v[6:0], cin};
      end
      cpualu_pkg::FN_RRCA, cpualu_pkg::FN_RRC: begin
        rot_c = rot_v[0];
        rot_r = {rot_v[0], rot_v[7:1]};
      end
      cpualu_pkg::FN_RRA, cpualu_pkg::FN_RR: begin
        rot_c = rot_v[0];
        rot_r = {cin, rot_v[7:1]};
      end
      default: begin
        rot_c = 1'b0;
        rot_r = '0;
      end
    endcase
  end

  // decimal adjust; low nibble is untouched by the high correction
  always_comb begin
    daa_v = a;
    daa_c = cin;
    if (!flags_in.n) begin
      if (cin || (a > cpualu_pkg::DAA_LIMIT)) begin
        daa_v = daa_v + cpualu_pkg::DAA_HI;
        daa_c = 1'b1;
      end
      if (flags_in.h || (a[3:0] > cpualu_pkg::NIB_LIMIT)) begin
        daa_v = daa_v + cpualu_pkg::DAA_LO;
      end
    end else begin
      if (cin) begin
        daa_v = daa_v - cpualu_pkg::DAA_HI;
      end
      if (flags_in.h) begin
        daa_v = daa_v - cpualu_pkg::DAA_LO;
      end
    end
  end

  always_comb begin
    r8         = '0;
    res.value  = '0;
    res.writes = 1'b1;
    res.flags  = flags_in;
    case (cpualu_pkg::func_t'(func))
      cpualu_pkg::FN_ADD, cpualu_pkg::FN_ADC: begin
        r8        = sum9[7:0];
        res.flags = '{z: (r8 == 8'd0), n: 1'b0, h: hsum5[4], c: sum9[8]};
      end
      cpualu_pkg::FN_SUB, cpualu_pkg::FN_SBC: begin
        r8        = dif9[7:0];
        res.flags = '{z: (r8 == 8'd0), n: 1'b1, h: hdif5[4], c: dif9[8]};
      end
      cpualu_pkg::FN_CP: begin
        res.writes = 1'b0;
        res.flags  = '{z: (dif9[7:0] == 8'd0), n: 1'b1, h: hdif5[4], c: dif9[8]};
      end
      cpualu_pkg::FN_AND: begin
        r8        = a & b;
        res.flags = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      cpualu_pkg::FN_XOR: begin
        r8        = a ^ b;
        res.flags = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      cpualu_pkg::FN_OR: begin
        r8        = a | b;
        res.flags = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      cpualu_pkg::FN_INC: begin
        r8        = b + 8'd1;
        res.flags = '{z: (r8 == 8'd0), n: 1'b0, h: (b[3:0] == 4'hF), c: cin};
      end
      cpualu_pkg::FN_DEC: begin
        r8        = b - 8'd1;
        res.flags = '{z: (r8 == 8'd0), n: 1'b1, h: (b[3:0] == 4'h0), c: cin};
      end
      cpualu_pkg::FN_RLCA, cpualu_pkg::FN_RLA, cpualu_pkg::FN_RRCA, cpualu_pkg::FN_RRA: begin
        // accumulator rotates always clear Z
        r8        = rot_r;
        res.flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: rot_c};
      end
      cpualu_pkg::FN_RLC, cpualu_pkg::FN_RL, cpualu_pkg::FN_RRC, cpualu_pkg::FN_RR: begin
        r8        = rot_r;
        res.flags = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: rot_c};
      end
      cpualu_pkg::FN_SLA: begin
        r8        = {b[6:0], 1'b0};
        res.flags = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: b[7]};
      end
      cpualu_pkg::FN_SRA: begin
        r8        = {b[7], b[7:1]};
        res.flags = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: b[0]};
      end
      cpualu_pkg::FN_SRL: begin
        r8        = {1'b0, b[7:1]};
        res.flags = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: b[0]};
      end
      cpualu_pkg::FN_SWAP: begin
        r8        = {b[3:0], b[7:4]};
        res.flags = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      cpualu_pkg::FN_BIT: begin
        res.writes = 1'b0;
        res.flags  = '{z: !b[bit_index], n: 1'b0, h: 1'b1, c: cin};
      end
      cpualu_pkg::FN_RES: begin
        r8 = b & ~(8'd1 << bit_index);
      end
      cpualu_pkg::FN_SET: begin
        r8 = b | (8'd1 << bit_index);
      end
      cpualu_pkg::FN_DAA: begin
        r8        = daa_v;
        res.flags = '{z: (r8 == 8'd0), n: flags_in.n, h: 1'b0, c: daa_c};
      end
      cpualu_pkg::FN_CPL: begin
        r8        = ~a;
        res.flags = '{z: flags_in.z, n: 1'b1, h: 1'b1, c: flags_in.c};
      end
      cpualu_pkg::FN_SCF: begin
        res.writes = 1'b0;
        res.flags  = '{z: flags_in.z, n: 1'b0, h: 1'b0, c: 1'b1};
      end
      cpualu_pkg::FN_CCF: begin
        res.writes = 1'b0;
        res.flags  = '{z: flags_in.z, n: 1'b0, h: 1'b0, c: !cin};
      end
      cpualu_pkg::FN_ADD16, cpualu_pkg::FN_ADDSP: begin
        // value and flags come from the 16-bit adders below
        res.writes = 1'b1;
      end
      default: begin
        res.writes = 1'b0;
      end
    endcase

    // 16-bit forms override the byte result
    if (func == cpualu_pkg::FN_ADD16) begin
      res.value = add16[15:0];
      res.flags = '{z: flags_in.z, n: 1'b0, h: h16[12], c: add16[16]};
    end else if (func == cpualu_pkg::FN_ADDSP) begin
      res.value = operand_a + sp_ext;
      res.flags = '{z: 1'b0, n: 1'b0, h: sp_h[4], c: sp_c[8]};
    end else begin
      res.value = {8'd0, r8};
    end
  end

endmodule

[src/cpu_alu_with_flags_unit.sv]
// Top level: input register, ALU datapath, result register and flag register.
//
// 8-bit CPU ALU with a Z/N/H/C flag register kept inside the block. Each
// word on the in_ channel carries an operation code, two 16-bit operands
// (8-bit operations use the low bytes, ADD16/ADDSP the full width) and a
// bit index; each word yields exactly one result word on the out_ channel
// with the value, a write-back enable and the flags after the operation.
// Words are handled strictly in order: the flags used by a word are those
// left by the word before it. A word passes the input register and then the
// result register before out_valid shows it; throughput is one word per
// clock as long as out_ready is high, since the whole operation plus the
// flag update fits in the single logic stage between the two registers.
// When out_ready is low the result register holds, the input register
// still takes one more word, and in_ready then drops. Reset clears the
// flags and empties both registers. Reserved codes (31 and up) return
// zero, no write, and leave the flags as they were.
module cpu_alu_with_flags_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [5:0]  in_func,
  input  logic [15:0] in_operand_a,
  input  logic [15:0] in_operand_b,
  input  logic [2:0]  in_bit_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_result_value,
  output logic        out_writes_result,
  output logic        out_zero_flag,
  output logic        out_subtract_flag,
  output logic        out_half_carry_flag,
  output logic        out_carry_flag
);

  // input stage
  logic        s1_vld_r;
  logic        s1_vld_nxt;
  logic [5:0]  s1_func_r;
  logic [15:0] s1_a_r;
  logic [15:0] s1_b_r;
  logic [2:0]  s1_idx_r;

  // result stage
  logic        out_vld_r;
  logic        out_vld_nxt;
  cpualu_pkg::alu_res_t out_res_r;

  // kept flag register, updated as each word leaves the input stage
  cpualu_pkg::flags_t flags_r;
  cpualu_pkg::flags_t flags_nxt;

  cpualu_pkg::alu_res_t alu_res;

  logic in_take;
  logic s1_adv;
  logic out_take;

  assign out_take = out_vld_r && out_ready;
  // input stage moves on when the result register is empty or draining
  assign s1_adv   = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;
  assign in_take  = in_valid && in_ready;

  cpualu_core u_core (
    .func      (s1_func_r),
    .operand_a (s1_a_r),
    .operand_b (s1_b_r),
    .bit_index (s1_idx_r),
    .flags_in  (flags_r),
    .res       (alu_res)
  );

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_take) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (s1_adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_take) begin
      out_vld_nxt = 1'b0;
    end
  end

  assign flags_nxt = s1_adv ? alu_res.flags : flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      flags_r   <= '0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      flags_r   <= flags_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_func_r <= in_func;
      s1_a_r    <= in_operand_a;
      s1_b_r    <= in_operand_b;
      s1_idx_r  <= in_bit_index;
    end
    if (s1_adv) begin
      out_res_r <= alu_res;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_result_value    = out_res_r.value;
  assign out_writes_result   = out_res_r.writes;
  assign out_zero_flag       = out_res_r.flags.z;
  assign out_subtract_flag   = out_res_r.flags.n;
  assign out_half_carry_flag = out_res_r.flags.h;
  assign out_carry_flag      = out_res_r.flags.c;

endmodule

[src/cpualu_checker.sv]
// Port-level assertions for the ALU top level, bound in below.
module cpualu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_result_value,
  input logic        out_writes_result,
  input logic        out_zero_flag,
  input logic        out_subtract_flag,
  input logic        out_half_carry_flag,
  input logic        out_carry_flag
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_result_value)
      && $stable(out_writes_result) && $stable(out_zero_flag)
      && $stable(out_subtract_flag) && $stable(out_half_carry_flag)
      && $stable(out_carry_flag)))
    else $error("stalled result word changed");

  // empty result register never blocks the input side
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output");

  // non-writing operations report a zero value
  a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_writes_result) |-> (out_result_value == 16'd0))
    else $error("non-writing word has nonzero value");

  // only the 16-bit adds produce an upper byte, and they always write
  a_upper_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_value[15:8] != 8'd0)) |-> out_writes_result)
    else $error("upper byte set without write");

endmodule

bind cpu_alu_with_flags_unit cpualu_checker u_cpualu_checker (.*);

[tb/sv/cpu_alu_with_flags_unit_test.sv]
// Self-checking testbench for the CPU ALU with kept Z/N/H/C flags.
module cpu_alu_with_flags_unit_test;

  // Reserved operation codes: no write, flags untouched
  localparam logic [5:0] FN_FIRST_RESERVED = 6'd31;
  localparam logic [5:0] FN_LAST_CODE      = 6'd63;

  // Cycles with no word moving on either side before the run is declared hung.
  // Random stalls are short; a few thousand is far beyond any correct run.
  localparam int STALL_LIMIT = 2000;
  // Cycles to wait after the last result so stray words would show up
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 1100;

  logic        clk;
  logic        rst_n               = 1'b0;
  logic        in_valid            = 1'b0;
  logic        in_ready;
  logic [5:0]  in_func             = '0;
  logic [15:0] in_operand_a        = '0;
  logic [15:0] in_operand_b        = '0;
  logic [2:0]  in_bit_index        = '0;
  logic        out_valid;
  logic        out_ready           = 1'b0;
  logic [15:0] out_result_value;
  logic        out_writes_result;
  logic        out_zero_flag;
  logic        out_subtract_flag;
  logic        out_half_carry_flag;
  logic        out_carry_flag;

  cpu_alu_with_flags_unit u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (in_func),
    .in_operand_a        (in_operand_a),
    .in_operand_b        (in_operand_b),
    .in_bit_index        (in_bit_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result_value    (out_result_value),
    .out_writes_result   (out_writes_result),
    .out_zero_flag       (out_zero_flag),
    .out_subtract_flag   (out_subtract_flag),
    .out_half_carry_flag (out_half_carry_flag),
    .out_carry_flag      (out_carry_flag)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One row of the directed table. Rows marked 'typed' carry a hand-written
  // result; all others are checked against the flag-tracking model below.
  typedef struct {
    logic [5:0]  code;
    logic [15:0] a;
    logic [15:0] b;
    logic [2:0]  idx;
    bit          typed;
    cpualu_pkg::alu_res_t res;
  } stim_row_t;

  stim_row_t  directed_rows[$];
  cpualu_pkg::alu_res_t alu_results_due[$];   // results owed by the DUT, oldest first
  cpualu_pkg::flags_t   flag_state;           // model copy of the block's flag register
  logic [15:0] last_value;          // last predicted value, feeds DAA chains
  bit         steady = 1'b0;        // both sides run without idling
  int         fail_count = 0;
  int         stall_cycles = 0;

  // Flag-tracking ALU model: computes one result word and advances the flags.
  function automatic cpualu_pkg::alu_res_t compute_alu_word(input logic [5:0] code,
                                                            input logic [15:0] a16,
                                                            input logic [15:0] b16,
                                                            input logic [2:0] idx);
    logic [7:0]  a, b, r8, v;
    logic [8:0]  sum9;
    logic [4:0]  nib;
    logic [12:0] sum13;
    logic [16:0] sum17;
    logic [15:0] r16;
    logic        cin, c, wr, wide, acc;
    cpualu_pkg::flags_t   f;
    cpualu_pkg::alu_res_t res;
    a = a16[7:0];
    b = b16[7:0];
    f = flag_state;
    cin = f.c;
    r8 = 8'h00;
    r16 = 16'h0000;
    wr = 1'b1;
    wide = 1'b0;
    case (code)
      cpualu_pkg::FN_ADD, cpualu_pkg::FN_ADC: begin
        c = (code == cpualu_pkg::FN_ADC) ? cin : 1'b0;
        sum9 = {1'b0, a} + {1'b0, b} + {8'h00, c};
        nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, c};
        r8 = sum9[7:0];
        f = '{r8 == 8'h00, 1'b0, nib[4], sum9[8]};
      end
      cpualu_pkg::FN_SUB, cpualu_pkg::FN_SBC, cpualu_pkg::FN_CP: begin
        // borrow flags: H from the low nibble, C from the whole byte
        c = (code == cpualu_pkg::FN_SBC) ? cin : 1'b0;
        r8 = a - b - {7'h00, c};
        f = '{r8 == 8'h00, 1'b1,
              {1'b0, a[3:0]} < {1'b0, b[3:0]} + {4'h0, c},
              {1'b0, a} < {1'b0, b} + {8'h00, c}};
        if (code == cpualu_pkg::FN_CP) begin
          r8 = 8'h00;
          wr = 1'b0;
        end
      end
      cpualu_pkg::FN_AND: begin
        r8 = a & b;
        f = '{r8 == 8'h00, 1'b0, 1'b1, 1'b0};
      end
      cpualu_pkg::FN_XOR: begin
        r8 = a ^ b;
        f = '{r8 == 8'h00, 1'b0, 1'b0, 1'b0};
      end
      cpualu_pkg::FN_OR: begin
        r8 = a | b;
        f = '{r8 == 8'h00, 1'b0, 1'b0, 1'b0};
      end
      cpualu_pkg::FN_INC: begin
        r8 = b + 8'h01;
        f = '{r8 == 8'h00, 1'b0, b[3:0] == 4'hF, cin};
      end
      cpualu_pkg::FN_DEC: begin
        r8 = b - 8'h01;
        f = '{r8 == 8'h00, 1'b1, b[3:0] == 4'h0, cin};
      end
      cpualu_pkg::FN_RLCA, cpualu_pkg::FN_RLA, cpualu_pkg::FN_RRCA, cpualu_pkg::FN_RRA,
      cpualu_pkg::FN_RLC, cpualu_pkg::FN_RL, cpualu_pkg::FN_RRC, cpualu_pkg::FN_RR: begin
        // accumulator forms work on A and always clear Z
        acc = (code == cpualu_pkg::FN_RLCA) || (code == cpualu_pkg::FN_RLA) ||
              (code == cpualu_pkg::FN_RRCA) || (code == cpualu_pkg::FN_RRA);
        v = acc ? a : b;
        if (code == cpualu_pkg::FN_RLCA || code == cpualu_pkg::FN_RLC) begin
          c = v[7];
          r8 = {v[6:0], v[7]};
        end else if (code == cpualu_pkg::FN_RLA || code == cpualu_pkg::FN_RL) begin
          c = v[7];
          r8 = {v[6:0], cin};
        end else if (code == cpualu_pkg::FN_RRCA || code == cpualu_pkg::FN_RRC) begin
          c = v[0];
          r8 = {v[0], v[7:1]};
        end else begin
          c = v[0];
          r8 = {cin, v[7:1]};
        end
        f = '{!acc && (r8 == 8'h00), 1'b0, 1'b0, c};
      end
      cpualu_pkg::FN_SLA: begin
        r8 = {b[6:0], 1'b0};
        f = '{r8 == 8'h00, 1'b0, 1'b0, b[7]};
      end
      cpualu_pkg::FN_SRA: begin
        r8 = {b[7], b[7:1]};
        f = '{r8 == 8'h00, 1'b0, 1'b0, b[0]};
      end
      cpualu_pkg::FN_SRL: begin
        r8 = {1'b0, b[7:1]};
        f = '{r8 == 8'h00, 1'b0, 1'b0, b[0]};
      end
      cpualu_pkg::FN_SWAP: begin
        r8 = {b[3:0], b[7:4]};
        f = '{r8 == 8'h00, 1'b0, 1'b0, 1'b0};
      end
      cpualu_pkg::FN_BIT: begin
        f = '{!b[idx], 1'b0, 1'b1, cin};
        wr = 1'b0;
      end
      cpualu_pkg::FN_RES: r8 = b & ~(8'h01 << idx);
      cpualu_pkg::FN_SET: r8 = b | (8'h01 << idx);
      cpualu_pkg::FN_DAA: begin
        v = a;
        c = cin;
        if (!f.n) begin
          if (c || v > cpualu_pkg::DAA_LIMIT) begin
            v = v + cpualu_pkg::DAA_HI;
            c = 1'b1;
          end
          if (f.h || v[3:0] > cpualu_pkg::NIB_LIMIT) v = v + cpualu_pkg::DAA_LO;
        end else begin
          if (c) v = v - cpualu_pkg::DAA_HI;
          if (f.h) v = v - cpualu_pkg::DAA_LO;
        end
        r8 = v;
        f = '{r8 == 8'h00, f.n, 1'b0, c};
      end
      cpualu_pkg::FN_CPL: begin
        r8 = ~a;
        f = '{f.z, 1'b1, 1'b1, f.c};
      end
      cpualu_pkg::FN_SCF: begin
        f = '{f.z, 1'b0, 1'b0, 1'b1};
        wr = 1'b0;
      end
      cpualu_pkg::FN_CCF: begin
        f = '{f.z, 1'b0, 1'b0, !cin};
        wr = 1'b0;
      end
      cpualu_pkg::FN_ADD16: begin
        // HL form: H out of bit 11, C out of bit 15, Z kept
        sum17 = {1'b0, a16} + {1'b0, b16};
        sum13 = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
        r16 = sum17[15:0];
        wide = 1'b1;
        f = '{f.z, 1'b0, sum13[12], sum17[16]};
      end
      cpualu_pkg::FN_ADDSP: begin
        // signed byte offset; flags come from the unsigned low-byte add
        r16 = a16 + {{8{b[7]}}, b};
        nib = {1'b0, a16[3:0]} + {1'b0, b[3:0]};
        sum9 = {1'b0, a16[7:0]} + {1'b0, b};
        wide = 1'b1;
        f = '{1'b0, 1'b0, nib[4], sum9[8]};
      end
      default: wr = 1'b0;  // reserved: nothing written, flags held
    endcase
    if (!wide) r16 = {8'h00, r8};
    flag_state = f;
    res.value = r16;
    res.writes = wr;
    res.flags = f;
    return res;
  endfunction

  task automatic add_row(input logic [5:0] code, input logic [15:0] a,
                         input logic [15:0] b, input logic [2:0] idx,
                         input bit typed = 1'b0, input logic [15:0] value = '0,
                         input logic wr = 1'b0, input logic [3:0] fl = '0);
    stim_row_t row;
    row.code = code;
    row.a = a;
    row.b = b;
    row.idx = idx;
    row.typed = typed;
    row.res.value = value;
    row.res.writes = wr;
    row.res.flags = cpualu_pkg::flags_t'(fl);
    directed_rows.push_back(row);
  endtask

  // Offer one word; random idle cycles go in front unless the run is steady.
  // The model steps at the edge that accepts the word, so flag order matches.
  task automatic send_word(input logic [5:0] code, input logic [15:0] a,
                           input logic [15:0] b, input logic [2:0] idx,
                           input bit typed, input cpualu_pkg::alu_res_t typed_res);
    cpualu_pkg::alu_res_t res;
    while (!steady && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= code;
    in_operand_a <= a;
    in_operand_b <= b;
    in_bit_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = compute_alu_word(code, a, b, idx);
    last_value = res.value;
    alu_results_due.push_back(typed ? typed_res : res);
  endtask

  // Operands lean on the corner values, the rest fully random
  function automatic logic [15:0] pick_operand();
    logic [15:0] corners[10];
    corners = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h0080,
                16'h007F, 16'h8000, 16'h7FFF, 16'h0FFF, 16'h000F};
    if ($urandom_range(3) == 0) return corners[$urandom_range(9)];
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_bcd();
    return {8'($urandom), 4'($urandom_range(9)), 4'($urandom_range(9))};
  endfunction

  // Receiver: random backpressure except in the steady stretch
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 35);
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Result side: every accepted word is matched against the oldest one owed
  always @(posedge clk) begin
    cpualu_pkg::alu_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (alu_results_due.size() == 0) begin
        $error("result_value: expected none, actual %0h", out_result_value);
        fail_count++;
      end else begin
        want = alu_results_due.pop_front();
        check_field("result_value", want.value, out_result_value);
        check_field("writes_result", 16'(want.writes), 16'(out_writes_result));
        check_field("zero_flag", 16'(want.flags.z), 16'(out_zero_flag));
        check_field("subtract_flag", 16'(want.flags.n), 16'(out_subtract_flag));
        check_field("half_carry_flag", 16'(want.flags.h), 16'(out_half_carry_flag));
        check_field("carry_flag", 16'(want.flags.c), 16'(out_carry_flag));
      end
    end
  end

  // Hang detection: cycles in which no word moves on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (rst_n);
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    cpualu_pkg::alu_res_t none;
    logic [5:0] code;
    logic [5:0] bcd_ops[4];
    none = '0;
    flag_state = '0;
    last_value = '0;
    bcd_ops = '{cpualu_pkg::FN_ADD, cpualu_pkg::FN_ADC, cpualu_pkg::FN_SUB,
                cpualu_pkg::FN_SBC};

    // Directed table. Typed rows: after reset, full-byte wrap, reserved code,
    // compare of equal values. Flags carry from row to row.
    add_row(cpualu_pkg::FN_ADD, 16'h0000, 16'h0000, 3'd0, 1'b1, 16'h0000, 1'b1, 4'b1000);
    add_row(cpualu_pkg::FN_ADD, 16'hFFFF, 16'hFF01, 3'd0, 1'b1, 16'h0000, 1'b1, 4'b1011);
    add_row(cpualu_pkg::FN_ADC, 16'h00FF, 16'h00FF, 3'd0);   // carry in from the wrap
    add_row(FN_LAST_CODE, 16'hFFFF, 16'hFFFF, 3'd7, 1'b1, 16'h0000, 1'b0, 4'b0011);
    add_row(cpualu_pkg::FN_SUB, 16'h0000, 16'h0001, 3'd0);   // borrow on nibble and byte
    add_row(cpualu_pkg::FN_SBC, 16'h0010, 16'h000F, 3'd0);   // borrow in brings it to zero
    add_row(cpualu_pkg::FN_CP, 16'h0042, 16'h0042, 3'd0, 1'b1, 16'h0000, 1'b0, 4'b1100);
    add_row(cpualu_pkg::FN_AND,   16'hFFFF, 16'hFFFF, 3'd0);
    add_row(cpualu_pkg::FN_XOR,   16'h00A5, 16'h00A5, 3'd0);
    add_row(cpualu_pkg::FN_OR,    16'h0000, 16'h0000, 3'd0);
    add_row(cpualu_pkg::FN_INC,   16'h0000, 16'h00FF, 3'd0);   // nibble carry, wraps to zero
    add_row(cpualu_pkg::FN_DEC,   16'h0000, 16'h0000, 3'd0);   // nibble borrow, wraps to FF
    add_row(cpualu_pkg::FN_SCF,   16'h0000, 16'h0000, 3'd0);
    add_row(cpualu_pkg::FN_CCF,   16'h0000, 16'h0000, 3'd0);
    add_row(cpualu_pkg::FN_RLCA,  16'hFF00, 16'h0000, 3'd0);   // zero result, Z stays clear
    add_row(cpualu_pkg::FN_RLA,   16'h0080, 16'h0000, 3'd0);
    add_row(cpualu_pkg::FN_RRCA,  16'h0001, 16'h0000, 3'd0);
    add_row(cpualu_pkg::FN_RRA,   16'h0000, 16'h0000, 3'd0);
    add_row(cpualu_pkg::FN_RLC,   16'h0000, 16'h0000, 3'd0);
    add_row(cpualu_pkg::FN_RL,    16'h0000, 16'h0080, 3'd0);
    add_row(cpualu_pkg::FN_RRC,   16'h0000, 16'h0001, 3'd0);
    add_row(cpualu_pkg::FN_RR,    16'h0000, 16'h0001, 3'd0);
    add_row(cpualu_pkg::FN_SLA,   16'h0000, 16'h0080, 3'd0);
    add_row(cpualu_pkg::FN_SRA,   16'h0000, 16'h0081, 3'd0);   // sign bit kept
    add_row(cpualu_pkg::FN_SRL,   16'h0000, 16'h0001, 3'd0);
    add_row(cpualu_pkg::FN_SWAP,  16'h0000, 16'h00F0, 3'd0);
    add_row(cpualu_pkg::FN_BIT,   16'h0000, 16'h007F, 3'd7);   // tested bit clear sets Z
    add_row(cpualu_pkg::FN_RES,   16'h0000, 16'h00FF, 3'd7);
    add_row(cpualu_pkg::FN_SET,   16'h0000, 16'h0000, 3'd0);
    add_row(cpualu_pkg::FN_ADD,   16'h0045, 16'h0038, 3'd0);
    add_row(cpualu_pkg::FN_DAA,   16'h007D, 16'h0000, 3'd0);   // low nibble past nine
    add_row(cpualu_pkg::FN_CPL,   16'h0000, 16'h0000, 3'd0);
    add_row(cpualu_pkg::FN_ADD16, 16'hFFFF, 16'h0001, 3'd0);   // carries out of bits 11, 15
    add_row(cpualu_pkg::FN_ADDSP, 16'hFFFF, 16'h0080, 3'd0);   // most negative offset

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_word(directed_rows[i].code, directed_rows[i].a, directed_rows[i].b,
                directed_rows[i].idx, directed_rows[i].typed, directed_rows[i].res);

    // Random part. Some iterations are BCD add/sub followed by DAA on the
    // result, so the decimal adjust sees real H/N/C combinations.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= 500 && i < 700);
      if ($urandom_range(99) < 15) begin
        send_word(bcd_ops[$urandom_range(3)], pick_bcd(), pick_bcd(),
                  3'($urandom), 1'b0, none);
        send_word(cpualu_pkg::FN_DAA, {8'($urandom), last_value[7:0]}, 16'($urandom),
                  3'($urandom), 1'b0, none);
      end else begin
        if ($urandom_range(99) < 6)
          code = 6'($urandom_range(FN_LAST_CODE, FN_FIRST_RESERVED));
        else
          code = 6'($urandom_range(cpualu_pkg::FN_ADDSP, cpualu_pkg::FN_ADD));
        send_word(code, pick_operand(), pick_operand(), 3'($urandom), 1'b0, none);
      end
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // Drain, then give stray words a chance to appear
    while (alu_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (alu_results_due.size() != 0) begin
      $error("result_value: %0d results never arrived", alu_results_due.size());
      fail_count++;
    end

    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
